[src/message_ring_fifo_assert.svh]
// assertion helpers for the message ring fifo
`ifndef MESSAGE_RING_FIFO_ASSERT_SVH
`define MESSAGE_RING_FIFO_ASSERT_SVH

// same-cycle implication, checked out of reset
`define MRF_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define MRF_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/mrf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mrf_pkg;

    localparam int SLOTS     = 16;
    localparam int MAX_BYTES = 64;
    localparam int IDX_W     = $clog2(SLOTS);
    localparam int OFF_W     = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
    localparam int MEM_DEPTH = SLOTS * MAX_BYTES;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);
    localparam int LEN_W     = 7;
    localparam int FILL_MAX  = 127;
    localparam int QDEPTH    = 2;
    localparam int QP_W      = $clog2(QDEPTH);

    localparam logic [1:0] KIND_PUT = 2'd0;
    localparam logic [1:0] KIND_GET = 2'd1;

    typedef enum logic [1:0] {
        OP_PUT,
        OP_GET,
        OP_POLL
    } t_op;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_MISMATCH = 3'd3,
        ST_OVERSIZE = 3'd4
    } t_status;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
        logic [6:0] req_len;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       run_end;
        t_status    status;
        logic [7:0] count;
        logic       is_empty;
        logic       is_full;
        logic [6:0] head_len;
    } t_out;

    typedef struct packed {
        t_op        op;
        logic [7:0] data;
        logic       last;
        logic [6:0] req_len;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry ent;
    } t_cmd;

endpackage

`default_nettype wire

[src/mrf_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module mrf_front import mrf_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire t_in  i_item,
    input  wire logic i_pop,
    output logic      o_busy,
    output t_cmd      o_head
);

    t_entry            r_q [QDEPTH];
    logic [QP_W-1:0]   r_wp;
    logic [QP_W-1:0]   r_rp;
    logic [QP_W:0]     r_cnt;
    logic [QP_W-1:0]   n_wp;
    logic [QP_W-1:0]   n_rp;
    logic [QP_W:0]     n_cnt;
    logic              push;
    logic              pop;
    t_entry            cls;

    // decode the item kind; the unused code behaves as a poll
    always_comb begin
        cls.data    = i_item.data;
        cls.last    = i_item.last;
        cls.req_len = i_item.req_len;
        case (i_item.kind)
            KIND_PUT: cls.op = OP_PUT;
            KIND_GET: cls.op = OP_GET;
            default:  cls.op = OP_POLL;
        endcase
    end

    assign o_busy = (r_cnt == (QP_W+1)'(QDEPTH));
    assign push   = i_start && !o_busy;
    assign pop    = i_pop && (r_cnt != '0);

    assign o_head.valid = (r_cnt != '0);
    assign o_head.ent   = r_q[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (push) begin
            n_wp = (r_wp == QP_W'(QDEPTH - 1)) ? '0 : r_wp + QP_W'(1);
        end
        if (pop) begin
            n_rp = (r_rp == QP_W'(QDEPTH - 1)) ? '0 : r_rp + QP_W'(1);
        end
        if (push && !pop) begin
            n_cnt = r_cnt + (QP_W+1)'(1);
        end else if (pop && !push) begin
            n_cnt = r_cnt - (QP_W+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cls;
        end
    end

endmodule

`default_nettype wire

[src/mrf_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module mrf_back import mrf_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cmd i_head,
    output logic      o_pop,
    output logic      o_strobe,
    output t_out      o_result
);

    typedef enum logic {
        S_IDLE,
        S_EMIT
    } t_state;

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_rd, n_rd;
    logic [IDX_W-1:0]   r_wr, n_wr;
    logic [LEN_W-1:0]   r_fill, n_fill;
    t_status            r_drop, n_drop;
    logic [MEM_AW-1:0]  r_eaddr, n_eaddr;
    logic [LEN_W-1:0]   r_rem, n_rem;
    logic               r_res_valid, n_res_valid;
    logic               r_res_has, n_res_has;
    logic               r_res_end, n_res_end;
    t_status            r_res_status, n_res_status;

    logic [7:0]         r_mem [MEM_DEPTH];
    logic [7:0]         r_rd_data;
    logic [LEN_W-1:0]   r_len [SLOTS];

    logic               mem_we;
    logic [MEM_AW-1:0]  mem_wa;
    logic               len_we;
    logic [LEN_W-1:0]   fill_inc;
    t_status            dm;
    logic [IDX_W-1:0]   wr_inc;
    logic [IDX_W-1:0]   rd_inc;
    logic               ring_full;
    logic               ring_empty;
    logic [LEN_W-1:0]   head_len;
    logic [IDX_W:0]     cnt_wide;

    assign wr_inc     = (r_wr == IDX_W'(SLOTS - 1)) ? '0 : r_wr + IDX_W'(1);
    assign rd_inc     = (r_rd == IDX_W'(SLOTS - 1)) ? '0 : r_rd + IDX_W'(1);
    assign ring_full  = (wr_inc == r_rd);
    assign ring_empty = (r_wr == r_rd);
    assign head_len   = r_len[r_rd];
    assign fill_inc   = (r_fill < LEN_W'(FILL_MAX)) ? r_fill + LEN_W'(1) : r_fill;
    assign mem_wa     = MEM_AW'(int'(r_wr) * MAX_BYTES) + MEM_AW'(r_fill[OFF_W-1:0]);

    always_comb begin
        if (r_wr >= r_rd) begin
            cnt_wide = {1'b0, r_wr} - {1'b0, r_rd};
        end else begin
            cnt_wide = {1'b0, r_wr} + (IDX_W+1)'(SLOTS) - {1'b0, r_rd};
        end
    end

    always_comb begin
        n_state      = r_state;
        n_rd         = r_rd;
        n_wr         = r_wr;
        n_fill       = r_fill;
        n_drop       = r_drop;
        n_eaddr      = r_eaddr;
        n_rem        = r_rem;
        n_res_valid  = 1'b0;
        n_res_has    = 1'b0;
        n_res_end    = 1'b1;
        n_res_status = ST_OK;
        mem_we       = 1'b0;
        len_we       = 1'b0;
        o_pop        = 1'b0;
        dm           = r_drop;
        case (r_state)
            S_IDLE: begin
                if (i_head.valid) begin
                    o_pop = 1'b1;
                    case (i_head.ent.op)
                        OP_PUT: begin
                            // full is judged once, at the first word of a message
                            if (r_fill == '0) begin
                                dm = ring_full ? ST_FULL : ST_OK;
                            end
                            if (dm == ST_OK) begin
                                if (r_fill < LEN_W'(MAX_BYTES)) begin
                                    mem_we = 1'b1;
                                end else begin
                                    dm = ST_OVERSIZE;
                                end
                            end
                            if (i_head.ent.last) begin
                                n_res_valid  = 1'b1;
                                n_res_status = dm;
                                if (dm == ST_OK) begin
                                    len_we = 1'b1;
                                    n_wr   = wr_inc;
                                end
                                n_fill = '0;
                                n_drop = ST_OK;
                            end else begin
                                n_fill = fill_inc;
                                n_drop = dm;
                            end
                        end
                        OP_GET: begin
                            if (ring_empty) begin
                                n_res_valid  = 1'b1;
                                n_res_status = ST_EMPTY;
                            end else if (head_len != i_head.ent.req_len || head_len == '0
                                         || head_len > LEN_W'(MAX_BYTES)) begin
                                n_res_valid  = 1'b1;
                                n_res_status = ST_MISMATCH;
                            end else begin
                                n_rd    = rd_inc;
                                n_eaddr = MEM_AW'(int'(r_rd) * MAX_BYTES);
                                n_rem   = head_len;
                                n_state = S_EMIT;
                            end
                        end
                        default: begin
                            n_res_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_EMIT: begin
                // memory read data lands together with the registered strobe
                n_eaddr     = r_eaddr + MEM_AW'(1);
                n_rem       = r_rem - LEN_W'(1);
                n_res_valid = 1'b1;
                n_res_has   = 1'b1;
                n_res_end   = (r_rem == LEN_W'(1));
                if (r_rem == LEN_W'(1)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_rd         <= '0;
            r_wr         <= '0;
            r_fill       <= '0;
            r_drop       <= ST_OK;
            r_eaddr      <= '0;
            r_rem        <= '0;
            r_res_valid  <= 1'b0;
            r_res_has    <= 1'b0;
            r_res_end    <= 1'b0;
            r_res_status <= ST_OK;
        end else begin
            r_state      <= n_state;
            r_rd         <= n_rd;
            r_wr         <= n_wr;
            r_fill       <= n_fill;
            r_drop       <= n_drop;
            r_eaddr      <= n_eaddr;
            r_rem        <= n_rem;
            r_res_valid  <= n_res_valid;
            r_res_has    <= n_res_has;
            r_res_end    <= n_res_end;
            r_res_status <= n_res_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= i_head.ent.data;
        end
        r_rd_data <= r_mem[r_eaddr];
    end

    always_ff @(posedge i_clk) begin
        if (len_we) begin
            r_len[r_wr] <= fill_inc;
        end
    end

    // ring status fields reflect the registers after the word that made the result
    assign o_strobe          = r_res_valid;
    assign o_result.out_byte = r_res_has ? r_rd_data : 8'd0;
    assign o_result.has_byte = r_res_has;
    assign o_result.run_end  = r_res_end;
    assign o_result.status   = r_res_status;
    assign o_result.count    = 8'(cnt_wide);
    assign o_result.is_empty = ring_empty;
    assign o_result.is_full  = ring_full;
    assign o_result.head_len = ring_empty ? '0 : head_len;

endmodule

`default_nettype wire

[src/message_ring_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none

// Message ring fifo: 16 slots of up to 64 bytes, one slot always left free.
// A word is taken when i_start is high and o_busy low; o_busy rises only when
// the two-entry command queue between the decoder and the execution engine is
// full. The engine retires one queued word per cycle for puts, polls and
// failed gets; a successful get holds it in the emit state for its n bytes,
// since the byte store has one read port and delivers one byte per cycle.
// Results come out registered, each valid for exactly one cycle on o_strobe,
// in the cycle after the engine takes the word (get bytes after emit state);
// the receiver cannot stall them and must take every result as it appears.
// Ring status fields in a result show the ring after that word was applied.
// No clearing pass after reset: stored bytes and lengths are read only after
// they have been written.

`include "message_ring_fifo_assert.svh"

module message_ring_fifo import mrf_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire t_in  i_item,
    output logic      o_busy,
    output logic      o_strobe,
    output t_out      o_result
);

    t_cmd head;
    logic pop;

    mrf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_item  (i_item),
        .i_pop   (pop),
        .o_busy  (o_busy),
        .o_head  (head)
    );

    mrf_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .o_pop    (pop),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    `MRF_ASSERT_IMP(a_byte_ok, o_strobe && o_result.has_byte,
        o_result.status == ST_OK, "byte with bad status")
    `MRF_ASSERT_IMP(a_not_both, o_strobe,
        !(o_result.is_empty && o_result.is_full), "empty and full")
    `MRF_ASSERT_IMP(a_empty_head, o_strobe && o_result.is_empty,
        o_result.head_len == '0 && o_result.count == '0, "empty ring reports data")
    `MRF_ASSERT_NXT(a_burst, o_strobe && o_result.has_byte && !o_result.run_end,
        o_strobe && o_result.has_byte, "get burst broken")

endmodule

`default_nettype wire

[dv/tb_message_ring_fifo.sv]
`timescale 1ns / 1ps

module tb_message_ring_fifo;
    import mrf_pkg::*;

    localparam logic [1:0] KIND_SPARE = 2'd3;   // decodes as a poll
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 24;
    localparam int ROUND_WORDS = 20;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_start = 1'b0;
    t_in  i_item = '0;
    logic o_busy;
    logic o_strobe;
    t_out o_result;

    message_ring_fifo u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_item   (i_item),
        .o_busy   (o_busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always #1 i_clk = ~i_clk;

    // ring state as the checker sees it
    logic [7:0] slot_mem [SLOTS*MAX_BYTES];
    logic [6:0] slot_len [SLOTS];
    int         rd_slot = 0;
    int         wr_slot = 0;
    int         put_fill = 0;
    t_status    put_drop = ST_OK;
    t_out       ring_replies [$];

    // stimulus and the generator's view of stored message lengths
    t_in        cmd_words [$];
    int         gen_lens [$];
    int         gen_fill = 0;
    bit         gen_drop = 1'b0;

    int         fail_count = 0;
    int         words_taken = 0;
    int         cycles = 0;
    logic       took_word = 1'b0;
    int         burst_left = 8;
    int         gap_left = 0;
    t_out       want;

    function automatic t_out ring_reply(logic [7:0] b, logic has, logic fin, t_status st);
        t_out r;
        r.out_byte = b;
        r.has_byte = has;
        r.run_end  = fin;
        r.status   = st;
        r.count    = 8'((wr_slot + SLOTS - rd_slot) % SLOTS);
        r.is_empty = (rd_slot == wr_slot);
        r.is_full  = (((wr_slot + 1) % SLOTS) == rd_slot);
        r.head_len = (rd_slot == wr_slot) ? 7'd0 : slot_len[rd_slot];
        return r;
    endfunction

    task automatic ring_apply(input t_in w);
        t_status st;
        int      len;
        int      base;
        case (w.kind)
            OP_PUT: begin
                if (put_fill == 0)
                    put_drop = (((wr_slot + 1) % SLOTS) == rd_slot) ? ST_FULL : ST_OK;
                if (put_drop == ST_OK) begin
                    if (put_fill < MAX_BYTES)
                        slot_mem[wr_slot*MAX_BYTES + put_fill] = w.data;
                    else
                        put_drop = ST_OVERSIZE;
                end
                if (put_fill < FILL_MAX)
                    put_fill++;
                if (w.last) begin
                    st = put_drop;
                    if (put_drop == ST_OK) begin
                        slot_len[wr_slot] = 7'(put_fill);
                        wr_slot = (wr_slot + 1) % SLOTS;
                    end
                    put_fill = 0;
                    put_drop = ST_OK;
                    ring_replies.push_back(ring_reply(8'd0, 1'b0, 1'b1, st));
                end
            end
            OP_GET: begin
                if (rd_slot == wr_slot) begin
                    ring_replies.push_back(ring_reply(8'd0, 1'b0, 1'b1, ST_EMPTY));
                end else begin
                    len = slot_len[rd_slot];
                    if (len != w.req_len || len == 0 || len > MAX_BYTES) begin
                        ring_replies.push_back(ring_reply(8'd0, 1'b0, 1'b1, ST_MISMATCH));
                    end else begin
                        base = rd_slot * MAX_BYTES;
                        rd_slot = (rd_slot + 1) % SLOTS;
                        for (int i = 0; i < len; i++)
                            ring_replies.push_back(ring_reply(slot_mem[base + i], 1'b1,
                                                              i == len - 1, ST_OK));
                    end
                end
            end
            default: ring_replies.push_back(ring_reply(8'd0, 1'b0, 1'b1, ST_OK));
        endcase
    endtask

    task automatic push_word(logic [1:0] kind, logic [7:0] data, logic fin, logic [6:0] req);
        t_in w;
        w.kind    = kind;
        w.data    = data;
        w.last    = fin;
        w.req_len = req;
        cmd_words.push_back(w);
    endtask

    task automatic put_byte(logic [7:0] data, logic fin);
        if (gen_fill == 0)
            gen_drop = (gen_lens.size() == SLOTS - 1);
        gen_fill++;
        push_word(OP_PUT, data, fin, 7'($urandom_range(0, 127)));
        if (fin) begin
            if (!gen_drop && gen_fill <= MAX_BYTES)
                gen_lens.push_back(gen_fill);
            gen_fill = 0;
        end
    endtask

    task automatic get_msg(int req);
        push_word(OP_GET, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 7'(req));
        if (gen_lens.size() > 0 && gen_lens[0] == req)
            void'(gen_lens.pop_front());
    endtask

    task automatic get_head();
        get_msg(gen_lens.size() > 0 ? gen_lens[0] : $urandom_range(0, MAX_BYTES));
    endtask

    task automatic poll_ring();
        push_word(($urandom_range(0, 3) == 0) ? KIND_SPARE : OP_POLL,
                  8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  7'($urandom_range(0, 127)));
    endtask

    // gets and polls may land between the bytes of a message
    task automatic put_message(int n, bit mix);
        for (int i = 0; i < n; i++) begin
            put_byte(8'($urandom_range(0, 255)), i == n - 1);
            if (mix && i < n - 1 && $urandom_range(0, 99) < 8) begin
                if ($urandom_range(0, 1) == 0)
                    get_head();
                else
                    poll_ring();
            end
        end
    endtask

    function automatic int msg_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return $urandom_range(1, 6);
        else if (r < 95)
            return $urandom_range(7, 20);
        return $urandom_range(MAX_BYTES - 4, MAX_BYTES + 4);
    endfunction

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
        if (exp_v !== got_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            fail_count++;
        end
    endtask

    task automatic build_words();
        int start_n;
        int r;
        // short directed opening
        poll_ring();
        push_word(KIND_SPARE, 8'h00, 1'b0, 7'd0);
        get_msg(0);
        put_byte(8'h00, 1'b1);
        put_byte(8'hff, 1'b0);
        put_byte(8'ha5, 1'b1);
        get_msg(2);
        get_msg(127);
        get_msg(1);
        put_byte(8'h5a, 1'b0);
        push_word(OP_POLL, 8'hff, 1'b1, 7'd127);
        get_msg(2);
        put_byte(8'hc3, 1'b1);
        get_msg(2);
        get_msg(64);
        // fill to full, then a message that starts on a full ring and sees a slot freed
        while (gen_lens.size() < SLOTS - 1)
            put_message($urandom_range(1, 2), 1'b0);
        put_byte(8'($urandom_range(0, 255)), 1'b0);
        get_head();
        put_byte(8'($urandom_range(0, 255)), 1'b1);
        put_message(MAX_BYTES, 1'b0);
        poll_ring();
        while (gen_lens.size() > 0)
            get_head();
        // oversize by one byte
        put_message(MAX_BYTES + 1, 1'b0);
        // random rounds, each leaning at random toward filling or draining
        start_n = cmd_words.size();
        while (cmd_words.size() - start_n < ROUND_WORDS) begin
            bit filling;
            filling = $urandom_range(0, 1);
            repeat ($urandom_range(4, 10)) begin
                r = $urandom_range(0, 99);
                if (r < (filling ? 70 : 25)) begin
                    put_message(msg_len(), 1'b1);
                end else if (r < 85) begin
                    case ($urandom_range(0, 5))
                        0: get_msg($urandom_range(0, 127));
                        1: get_msg(gen_lens.size() > 0 ? gen_lens[0] + 1 : 0);
                        default: get_head();
                    endcase
                end else begin
                    poll_ring();
                end
            end
        end
        // close any message left open
        if (gen_fill != 0)
            put_byte(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // driver: bursts with random gaps, new word after the previous one is taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else if (!i_start || took_word) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_start <= 1'b0;
            end else if (cmd_words.size() > 0) begin
                i_item <= cmd_words.pop_front();
                i_start <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    // monitor: predict on each taken word, check each strobed result
    always @(posedge i_clk) begin
        took_word <= i_rst_n && i_start && !o_busy;
        if (i_rst_n) begin
            if (i_start && !o_busy) begin
                ring_apply(i_item);
                words_taken <= words_taken + 1;
            end
            if (o_strobe) begin
                if (ring_replies.size() == 0) begin
                    $error("result with nothing pending: status %0d", o_result.status);
                    fail_count++;
                end else begin
                    want = ring_replies.pop_front();
                    check_field("out_byte", want.out_byte, o_result.out_byte);
                    check_field("has_byte", want.has_byte, o_result.has_byte);
                    check_field("run_end", want.run_end, o_result.run_end);
                    check_field("status", want.status, o_result.status);
                    check_field("count", want.count, o_result.count);
                    check_field("is_empty", want.is_empty, o_result.is_empty);
                    check_field("is_full", want.is_full, o_result.is_full);
                    check_field("head_len", want.head_len, o_result.head_len);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        int total;
        build_words();
        total = cmd_words.size();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        while (words_taken != total)
            @(negedge i_clk);
        while (ring_replies.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
